// ===== hdl/uuidp_pkg.sv =====
package uuidp_pkg;

    localparam int unsigned TEXT_LEN  = 36;
    localparam int unsigned POS_W     = 6;
    localparam int unsigned DIGITS_W  = 128;
    localparam int unsigned WORD_W    = 64;

    localparam logic [POS_W-1:0] TEXT_LEN_POS = POS_W'(TEXT_LEN);
    localparam logic [POS_W-1:0] DASH_POS_A   = 6'd8;
    localparam logic [POS_W-1:0] DASH_POS_B   = 6'd13;
    localparam logic [POS_W-1:0] DASH_POS_C   = 6'd18;
    localparam logic [POS_W-1:0] DASH_POS_D   = 6'd23;

    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_F  = 8'h46;
    localparam logic [7:0] CHAR_LOW_A = 8'h61;
    localparam logic [7:0] CHAR_LOW_F = 8'h66;

    // byte_order register codes; the unused code behaves as ORDER_GUID
    localparam logic [1:0] ORDER_STD  = 2'd0;
    localparam logic [1:0] ORDER_GUID = 2'd1;
    localparam logic [1:0] ORDER_LE   = 2'd2;
    localparam logic [1:0] ORDER_RSVD = 2'd3;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    typedef struct packed {
        logic [1:0] byte_order;
        logic       ok;
    } fmt_ctl_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t r;
        r.ok  = 1'b0;
        r.val = 4'd0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            r.ok  = 1'b1;
            r.val = c[3:0];
        end else if ((c >= CHAR_LOW_A && c <= CHAR_LOW_F) ||
                     (c >= CHAR_UP_A && c <= CHAR_UP_F)) begin
            r.ok  = 1'b1;
            r.val = 4'(c[3:0] + 4'd9);
        end
        return r;
    endfunction

endpackage

// ===== hdl/uuidp_fmt.sv =====
module uuidp_fmt import uuidp_pkg::*; (
    input  logic [DIGITS_W-1:0] digits,
    input  fmt_ctl_t            ctl,
    output logic [WORD_W-1:0]   uuid_upper,
    output logic [WORD_W-1:0]   uuid_lower
);

    logic [7:0] b [16];
    logic [7:0] o [16];

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            b[i] = digits[DIGITS_W-1-8*i -: 8];
            o[i] = b[i];
        end
        unique case (ctl.byte_order)
            ORDER_STD: begin
            end
            ORDER_GUID, ORDER_RSVD, ORDER_LE: begin
                // reverse time_low, time_mid, time_hi
                o[0] = b[3];
                o[1] = b[2];
                o[2] = b[1];
                o[3] = b[0];
                o[4] = b[5];
                o[5] = b[4];
                o[6] = b[7];
                o[7] = b[6];
                if (ctl.byte_order == ORDER_LE) begin
                    o[8] = b[9];
                    o[9] = b[8];
                    for (int j = 0; j < 6; j++) begin
                        o[10+j] = b[15-j];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            uuid_upper[WORD_W-1-8*i -: 8] = ctl.ok ? o[i]   : 8'd0;
            uuid_lower[WORD_W-1-8*i -: 8] = ctl.ok ? o[8+i] : 8'd0;
        end
    end

endmodule

// ===== hdl/uuid_text_parser.sv =====
// Channel    Dir  Payload (low bit up)                      Sideband
// s_axis     in   tdata[7:0] ch                             tlast = last
// m_axis     out  tdata[63:0] uuid_upper, [127:64] lower    tuser = ok
// cfg        in   cfg_wr_data[1:0] byte_order               cfg_wr_en
//
// One character is taken per cycle; the result of a last-flagged character
// appears in the output register on the next cycle.
// The rate is set by the single output register: input stalls only while
// a finished result sits unclaimed.
// Reset (aresetn low, synchronous) clears position, fault flag, gathered
// digits, output valid and byte_order.
module uuid_text_parser import uuidp_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_wr_data,   // byte_order
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,  // [7:0] ch
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [2*WORD_W-1:0]   m_axis_tdata,  // [63:0] uuid_upper, [127:64] uuid_lower
    output logic                  m_axis_tuser   // [0] ok
);

    logic [1:0]          byte_order_reg;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                valid_reg, valid_next;
    logic [DIGITS_W-1:0] digits_reg, digits_next;
    logic                m_valid_reg;
    logic [WORD_W-1:0]   m_upper_reg, m_lower_reg;
    logic                m_ok_reg;

    logic          accept;
    logic          past_end;
    logic          dash_pos;
    hex_t          hex;
    fmt_ctl_t      fmt_ctl;
    logic [WORD_W-1:0] fmt_upper, fmt_lower;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        hex      = hex_decode(s_axis_tdata);
        past_end = (pos_reg >= TEXT_LEN_POS);
        dash_pos = (pos_reg == DASH_POS_A) || (pos_reg == DASH_POS_B) ||
                   (pos_reg == DASH_POS_C) || (pos_reg == DASH_POS_D);
        pos_next    = pos_reg;
        valid_next  = valid_reg;
        digits_next = digits_reg;
        priority if (past_end) begin
            valid_next = 1'b0;
        end else begin
            pos_next = pos_reg + 1'b1;
            if (dash_pos) begin
                if (s_axis_tdata != CHAR_DASH) begin
                    valid_next = 1'b0;
                end
            end else if (!hex.ok) begin
                valid_next = 1'b0;
            end else begin
                digits_next = {digits_reg[DIGITS_W-5:0], hex.val};
            end
        end
    end

    assign fmt_ctl.byte_order = byte_order_reg;
    assign fmt_ctl.ok         = valid_next && (pos_next == TEXT_LEN_POS);

    uuidp_fmt u_fmt (
        .digits     (digits_next),
        .ctl        (fmt_ctl),
        .uuid_upper (fmt_upper),
        .uuid_lower (fmt_lower)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_order_reg <= ORDER_STD;
        end else if (cfg_wr_en) begin
            byte_order_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            valid_reg  <= 1'b1;
            digits_reg <= '0;
        end else if (accept) begin
            if (s_axis_tlast) begin
                // drop back to the idle state for the next string
                pos_reg    <= '0;
                valid_reg  <= 1'b1;
                digits_reg <= '0;
            end else begin
                pos_reg    <= pos_next;
                valid_reg  <= valid_next;
                digits_reg <= digits_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            m_valid_reg <= accept && s_axis_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_axis_tlast) begin
            m_upper_reg <= fmt_upper;
            m_lower_reg <= fmt_lower;
            m_ok_reg    <= fmt_ctl.ok;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_lower_reg, m_upper_reg};
    assign m_axis_tuser  = m_ok_reg;

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= TEXT_LEN_POS)
        else $error("character position ran past the text length");

    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_axis_tlast) |=> (m_axis_tvalid && pos_reg == '0 && valid_reg))
        else $error("last character did not produce a result and clear state");

    a_bad_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("invalid result carries nonzero data");

    a_short_fails: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_axis_tlast && pos_reg != (TEXT_LEN_POS - 1'b1)) |=> !m_axis_tuser)
        else $error("string of wrong length reported as valid");

endmodule
